### design/bba_pkg.sv
`default_nettype none
package bba_pkg;

    localparam int MAP_BLOCKS   = 4096;
    localparam int WORD_BITS    = 8;
    localparam int ROW_BITS     = 64;
    localparam int MAP_ROWS     = MAP_BLOCKS / ROW_BITS;
    localparam int ROW_IDX_W    = $clog2(MAP_ROWS);
    localparam int BIT_IDX_W    = $clog2(ROW_BITS);
    localparam int BLOCK_W      = 12;
    localparam int LIMIT_W      = 13;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(MAP_BLOCKS);

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MARK    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [BLOCK_W-1:0] block;
    } t_req;

    typedef struct packed {
        logic [BLOCK_W-1:0]  granted_block;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    typedef struct packed {
        logic                 rd_en;
        logic [ROW_IDX_W-1:0] rd_addr;
        logic                 wr_en;
        logic [ROW_IDX_W-1:0] wr_addr;
        logic [ROW_BITS-1:0]  wr_data;
    } t_map_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RMW
    } t_state;

endpackage
`default_nettype wire

### design/bitmap_block_allocator_unit.sv
// Allocate: busy while rows are scanned (1..64 rows); the result strobe comes in the cycle after the last busy one.
// Release / mark-used: busy in the RMW state only; out of range or unused command: never busy.
// Rate is set by the row scan: one 64-block row of the map per cycle, one memory read port.
// Reset (synchronous, active low) clears row valid bits at once, so the map reads as
// all free with no clearing pass; the limit returns to 4096. Results cannot be stalled.
`default_nettype none
module bitmap_block_allocator_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire bba_pkg::t_req                i_req,
    output logic                              o_strobe,
    output bba_pkg::t_rsp                     o_rsp,
    input  wire logic                         i_cfg_we,
    input  wire logic [bba_pkg::LIMIT_W-1:0]  i_cfg_wdata
);

    bba_pkg::t_state r_state, n_state;
    logic [bba_pkg::CMD_W-1:0]     r_cmd;
    logic [bba_pkg::BLOCK_W-1:0]   r_block;
    logic [bba_pkg::ROW_IDX_W-1:0] r_row, n_row;
    logic [bba_pkg::LIMIT_W-1:0]   r_limit;
    logic                          r_strobe, n_strobe;
    bba_pkg::t_rsp                 r_rsp, n_rsp;

    bba_pkg::t_map_ctl             map_ctl;
    logic [bba_pkg::ROW_BITS-1:0]  rd_data;
    logic [bba_pkg::LIMIT_W-1:0]   eff_limit;
    logic                          accept;
    logic                          is_alloc;
    logic                          is_update;
    logic                          in_range;
    logic                          scan_hit;
    logic [bba_pkg::BIT_IDX_W-1:0] scan_bit;
    logic                          scan_last;
    logic [bba_pkg::ROW_BITS-1:0]  upd_bit;

    // saturate the limit to the map size
    assign eff_limit = (r_limit > bba_pkg::LIMIT_MAX) ? bba_pkg::LIMIT_MAX : r_limit;

    assign accept    = i_start && (r_state == bba_pkg::S_IDLE);
    assign is_alloc  = (i_req.command == bba_pkg::CMD_ALLOC);
    assign is_update = (i_req.command == bba_pkg::CMD_RELEASE) ||
                       (i_req.command == bba_pkg::CMD_MARK);
    assign in_range  = ({1'b0, i_req.block} < eff_limit);

    // one-hot of the block bit inside its row for release / mark-used
    assign upd_bit = bba_pkg::ROW_BITS'(1) << r_block[bba_pkg::BIT_IDX_W-1:0];

    bba_map_ram u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (map_ctl),
        .o_rd_data (rd_data)
    );

    bba_scan_unit u_scan (
        .i_row_data (rd_data),
        .i_row      (r_row),
        .i_limit    (eff_limit),
        .o_hit      (scan_hit),
        .o_bit      (scan_bit),
        .o_last     (scan_last)
    );

    // Next state: hold in SCAN until a free block turns up or the limit is reached.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::S_IDLE: begin
                if (accept) begin
                    if (is_alloc) begin
                        n_state = bba_pkg::S_SCAN;
                    end else if (is_update && in_range) begin
                        n_state = bba_pkg::S_RMW;
                    end
                end
            end
            bba_pkg::S_SCAN: begin
                if (scan_hit || scan_last) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_RMW: begin
                n_state = bba_pkg::S_IDLE;
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: map reads and writes, row pointer, next result.
    always_comb begin
        map_ctl  = '0;
        n_row    = r_row;
        n_strobe = 1'b0;
        n_rsp    = '0;
        unique case (r_state)
            bba_pkg::S_IDLE: begin
                n_row = '0;
                if (accept) begin
                    if (is_alloc) begin
                        // fetch row 0; the scan starts next cycle
                        map_ctl.rd_en   = 1'b1;
                        map_ctl.rd_addr = '0;
                    end else if (is_update && in_range) begin
                        map_ctl.rd_en   = 1'b1;
                        map_ctl.rd_addr =
                            i_req.block[bba_pkg::BLOCK_W-1:bba_pkg::BIT_IDX_W];
                    end else if (is_update) begin
                        n_strobe     = 1'b1;
                        n_rsp.status = bba_pkg::ST_RANGE;
                    end else begin
                        // unused command: report ok, change nothing
                        n_strobe     = 1'b1;
                        n_rsp.status = bba_pkg::ST_OK;
                    end
                end
            end
            bba_pkg::S_SCAN: begin
                if (scan_hit) begin
                    // claim the block: clear its bit in the row just read
                    map_ctl.wr_en   = 1'b1;
                    map_ctl.wr_addr = r_row;
                    map_ctl.wr_data = rd_data &
                                      ~(bba_pkg::ROW_BITS'(1) << scan_bit);
                    n_strobe            = 1'b1;
                    n_rsp.status        = bba_pkg::ST_OK;
                    n_rsp.granted_block = {r_row, scan_bit};
                end else if (scan_last) begin
                    n_strobe     = 1'b1;
                    n_rsp.status = bba_pkg::ST_FULL;
                end else begin
                    // advance: fetch the next row while this one is checked
                    map_ctl.rd_en   = 1'b1;
                    map_ctl.rd_addr = r_row + bba_pkg::ROW_IDX_W'(1);
                    n_row           = r_row + bba_pkg::ROW_IDX_W'(1);
                end
            end
            bba_pkg::S_RMW: begin
                map_ctl.wr_en   = 1'b1;
                map_ctl.wr_addr = r_block[bba_pkg::BLOCK_W-1:bba_pkg::BIT_IDX_W];
                map_ctl.wr_data = (r_cmd == bba_pkg::CMD_RELEASE) ?
                                  (rd_data | upd_bit) : (rd_data & ~upd_bit);
                n_strobe        = 1'b1;
                n_rsp.status    = bba_pkg::ST_OK;
            end
            default: begin
                n_row = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bba_pkg::S_IDLE;
            r_strobe <= 1'b0;
            r_limit  <= bba_pkg::LIMIT_RESET;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_rsp <= n_rsp;
        if (accept) begin
            r_cmd   <= i_req.command;
            r_block <= i_req.block;
        end
    end

    assign o_busy   = (r_state != bba_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
`default_nettype wire

### design/bba_map_ram.sv
`default_nettype none
module bba_map_ram (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bba_pkg::t_map_ctl            i_ctl,
    output logic [bba_pkg::ROW_BITS-1:0]      o_rd_data
);

    logic [bba_pkg::ROW_BITS-1:0] r_mem [bba_pkg::MAP_ROWS];
    logic [bba_pkg::MAP_ROWS-1:0] r_valid;
    logic [bba_pkg::ROW_BITS-1:0] r_rd_raw;
    logic                         r_rd_valid;

    // a row never written reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_ctl.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_raw   <= r_mem[i_ctl.rd_addr];
            r_rd_valid <= r_valid[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_raw : '1;

endmodule
`default_nettype wire

### design/bba_scan_unit.sv
`default_nettype none
module bba_scan_unit (
    input  wire logic [bba_pkg::ROW_BITS-1:0]  i_row_data,
    input  wire logic [bba_pkg::ROW_IDX_W-1:0] i_row,
    input  wire logic [bba_pkg::LIMIT_W-1:0]   i_limit,
    output logic                               o_hit,
    output logic [bba_pkg::BIT_IDX_W-1:0]      o_bit,
    output logic                               o_last
);

    logic [bba_pkg::LIMIT_W-1:0]  base;
    logic [bba_pkg::LIMIT_W-1:0]  top;
    logic [bba_pkg::LIMIT_W-1:0]  rem;
    logic [bba_pkg::ROW_BITS-1:0] mask;
    logic [bba_pkg::ROW_BITS-1:0] masked;

    assign base = {1'b0, i_row, {bba_pkg::BIT_IDX_W{1'b0}}};
    assign top  = base + bba_pkg::LIMIT_W'(bba_pkg::ROW_BITS);
    assign rem  = i_limit - base;

    // keep only blocks below the limit
    always_comb begin
        if (i_limit >= top) begin
            mask = '1;
        end else if (i_limit <= base) begin
            mask = '0;
        end else begin
            mask = (bba_pkg::ROW_BITS'(1) << rem[bba_pkg::BIT_IDX_W-1:0])
                   - bba_pkg::ROW_BITS'(1);
        end
    end

    assign masked = i_row_data & mask;
    assign o_hit  = |masked;
    assign o_last = (i_limit <= top);

    // lowest set bit wins
    always_comb begin
        o_bit = '0;
        for (int b = bba_pkg::ROW_BITS - 1; b >= 0; b--) begin
            if (masked[b]) begin
                o_bit = bba_pkg::BIT_IDX_W'(b);
            end
        end
    end

endmodule
`default_nettype wire

### tb/testbench.sv
`default_nettype none
import bba_pkg::*;

// Scoreboard: keeps its own free map and limit, predicts one response per request
// and checks responses in order.
class alloc_scoreboard;
    bit                 free_bits [MAP_BLOCKS];
    logic [LIMIT_W-1:0] limit;
    t_rsp               grants [$];
    int unsigned        errors;

    function new();
        foreach (free_bits[n]) free_bits[n] = 1'b1;
        limit  = LIMIT_RESET;
        errors = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
        limit = v;
    endfunction

    function int unsigned pending();
        return grants.size();
    endfunction

    // Apply one accepted request to the map and queue the response it yields.
    function void take_request(t_req r);
        int unsigned lim;
        int          hit;
        t_rsp        exp_rsp;
        lim = (limit > LIMIT_MAX) ? MAP_BLOCKS : int'(limit);
        exp_rsp = '0;
        exp_rsp.status = ST_OK;
        case (r.command)
            CMD_ALLOC: begin
                hit = -1;
                for (int n = 0; n < lim; n++) begin
                    if (free_bits[n]) begin
                        hit = n;
                        break;
                    end
                end
                if (hit < 0) begin
                    exp_rsp.status = ST_FULL;
                end else begin
                    free_bits[hit] = 1'b0;
                    exp_rsp.granted_block = BLOCK_W'(hit);
                end
            end
            CMD_RELEASE, CMD_MARK: begin
                if (int'(r.block) >= lim)
                    exp_rsp.status = ST_RANGE;
                else
                    free_bits[r.block] = (r.command == CMD_RELEASE);
            end
            default: ;
        endcase
        grants.push_back(exp_rsp);
    endfunction

    function void check_grant(t_rsp got);
        t_rsp exp_rsp;
        if (grants.size() == 0) begin
            $error("response with no request outstanding: granted_block %0d status %0d",
                   got.granted_block, got.status);
            errors++;
            return;
        end
        exp_rsp = grants.pop_front();
        if (got.granted_block !== exp_rsp.granted_block) begin
            $error("granted_block: expected %0d, actual %0d",
                   exp_rsp.granted_block, got.granted_block);
            errors++;
        end
        if (got.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, got.status);
            errors++;
        end
    endfunction
endclass

module testbench;

    // Command code the block leaves unused; it must answer ok with block 0.
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int NUM_PHASES = 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    t_req               i_req;
    logic               o_strobe;
    t_rsp               o_rsp;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;

    alloc_scoreboard sb;
    int unsigned     cycles = 0;

    // Limit per random phase; -1 picks a random one. Extremes, a limit above the
    // map size, a limit that is not a multiple of a byte, and zero all appear.
    int phase_limit [NUM_PHASES] =
        '{8, 4096, 100, 1, 8191, 64, 13, 4097, 200, 0, -1, -1, -1, 8, 4096, -1};
    // Request count per phase; the long 4096 phase marks a growing run of blocks
    // so that allocates have to scan deep into the map.
    int unsigned phase_count [NUM_PHASES] =
        '{115, 300, 115, 115, 115, 115, 115, 115, 115, 40, 115, 115, 115, 115, 115, 115};

    bitmap_block_allocator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Monitor: note the accepted request first, so a response in the same cycle
    // still finds its prediction queued.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy)
                sb.take_request(i_req);
            if (o_strobe)
                sb.check_grant(o_rsp);
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_req req_of(logic [CMD_W-1:0] c, logic [BLOCK_W-1:0] b);
        t_req r;
        r.command = c;
        r.block   = b;
        return r;
    endfunction

    // Present one request and hold it until the block takes it. Optionally drop
    // start for a short burst first.
    task automatic send_request(input t_req r, input bit gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Hold off new requests until every response is back, then let the block settle.
    task automatic wait_drained();
        i_start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        sb.set_limit(v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int code, input int unsigned count, input bit gaps);
        logic [LIMIT_W-1:0] lim_val;
        int unsigned        lim;
        int unsigned        sweep;
        int unsigned        sel;
        int unsigned        pick;
        bit                 deep;
        logic [CMD_W-1:0]   cmd;
        logic [BLOCK_W-1:0] blk;
        if (code < 0)
            lim_val = ($urandom_range(0, 3) == 0) ? LIMIT_W'($urandom_range(0, 8191))
                                                  : LIMIT_W'($urandom_range(8, 300));
        else
            lim_val = LIMIT_W'(code);
        wait_drained();
        write_limit(lim_val);
        lim   = (lim_val > LIMIT_MAX) ? MAP_BLOCKS : int'(lim_val);
        deep  = (count > 200);
        sweep = 0;
        repeat (count) begin
            sel  = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            if (pick < 8)
                blk = (lim > 0) ? BLOCK_W'($urandom_range(0, lim - 1)) : '0;
            else if (pick == 8)
                blk = BLOCK_W'($urandom_range(lim, lim + 7));
            else
                blk = BLOCK_W'($urandom_range(0, 4095));
            if (deep) begin
                // Grow a used run from block 0 with a few allocates and releases mixed in.
                if (sel < 70) begin
                    cmd   = CMD_MARK;
                    blk   = BLOCK_W'(sweep);
                    sweep = sweep + 1;
                end else if (sel < 90) begin
                    cmd = CMD_ALLOC;
                end else begin
                    cmd = CMD_RELEASE;
                    blk = BLOCK_W'($urandom_range(0, 4095));
                end
            end else begin
                if (sel < 45)
                    cmd = CMD_ALLOC;
                else if (sel < 70)
                    cmd = CMD_RELEASE;
                else if (sel < 93)
                    cmd = CMD_MARK;
                else
                    cmd = CMD_NONE;
            end
            send_request(req_of(cmd, blk), gaps);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset limit: first grants, repeated release and mark, unused command.
        send_request(req_of(CMD_ALLOC, 12'd4095), 1'b1);
        send_request(req_of(CMD_ALLOC, 12'd0), 1'b1);
        send_request(req_of(CMD_RELEASE, 12'd0), 1'b1);
        send_request(req_of(CMD_RELEASE, 12'd0), 1'b1);
        send_request(req_of(CMD_ALLOC, 12'd0), 1'b1);
        send_request(req_of(CMD_MARK, 12'd4095), 1'b1);
        send_request(req_of(CMD_MARK, 12'd4095), 1'b1);
        send_request(req_of(CMD_RELEASE, 12'd4095), 1'b1);
        send_request(req_of(CMD_NONE, 12'd4095), 1'b1);

        // Zero limit: nothing to grant, every block out of range.
        wait_drained();
        write_limit('0);
        send_request(req_of(CMD_ALLOC, 12'd0), 1'b1);
        send_request(req_of(CMD_RELEASE, 12'd0), 1'b1);
        send_request(req_of(CMD_MARK, 12'd4095), 1'b1);

        // Limit above the map size saturates.
        wait_drained();
        write_limit('1);
        send_request(req_of(CMD_RELEASE, 12'd4095), 1'b1);
        send_request(req_of(CMD_ALLOC, 12'd0), 1'b1);

        // Limit inside the second byte: allocate through the partial byte until the map is full.
        wait_drained();
        write_limit(LIMIT_W'(13));
        repeat (11) send_request(req_of(CMD_ALLOC, 12'd0), 1'b1);

        // Random phases; the last three send their requests back to back with no idling.
        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(phase_limit[p], phase_count[p], p < NUM_PHASES - 3);

        wait_drained();
        repeat (70) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
